>>> rtl/all_pairs_shortest_path_assert.svh
// Assertion macros for the all-pairs shortest path block.
// Depends on nothing; included by the top level, which does the asserting.
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define APSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsp: same-cycle check failed");
// next-cycle implication
`define APSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apsp: next-cycle check failed");
`else
`define APSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define APSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/apsp_pkg.sv
// Shared types and fixed constants for the all-pairs shortest path block.
// No dependencies.
`default_nettype none

package apsp_pkg;

    localparam int WEIGHT_W  = 16;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 7;
    localparam int CFG_RESET = 64;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_cmd;

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/all_pairs_shortest_path.sv
// All-pairs shortest path (Floyd-Warshall) over a stored distance matrix.
// Depends on apsp_pkg, apsp_ram and all_pairs_shortest_path_assert.svh.
//
// Usage:
//   Command channel: a transaction is taken on a clock edge with start high and
//   busy low. Opcode load writes the next weight in row-major order; after the
//   N*N-th weight the block relaxes the matrix on its own. Opcode read returns
//   the next distance in row-major order; the final one carries last.
//   Commands that do not fit the current phase are taken and dropped.
//   Result channel: o_valid marks o_res for exactly one cycle, in the cycle after
//   the read was taken. The receiver cannot stall; nothing is held back.
//   Config: i_cfg_we/i_cfg_data write the vertex count N (0 acts as 1, values
//   above MAX_VERTICES clamp) and restart the job; write only while idle.
// Timing:
//   Loads and reads may come back to back.
//   Relaxation holds busy: per pivot and row a via step fetches the row's
//   via-pivot distance, then a cell step per column reads the pivot row and
//   the cell on the two RAM read ports; the single RAM write port retires one
//   cell per cycle, pausing around each via step.
// Reset: N = 64 (clamped to MAX_VERTICES), loading phase, matrix undefined.
`default_nettype none

`include "all_pairs_shortest_path_assert.svh"

module all_pairs_shortest_path #(
    parameter int MAX_VERTICES = 64,
    parameter int DIST_WIDTH   = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire apsp_pkg::t_cmd                i_cmd,
    // result channel
    output logic                               o_valid,
    output apsp_pkg::t_res                     o_res,
    // vertex count register
    input  wire logic                          i_cfg_we,
    input  wire logic [apsp_pkg::CFG_W-1:0]    i_cfg_data
);

    // index and address widths
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NW > apsp_pkg::CFG_W) ? NW : apsp_pkg::CFG_W;
    localparam int LW    = DIST_WIDTH + apsp_pkg::WEIGHT_W;
    localparam int XW    = DIST_WIDTH + apsp_pkg::OUT_W;
    localparam int RST_SIDE = (MAX_VERTICES < apsp_pkg::CFG_RESET) ?
                              MAX_VERTICES : apsp_pkg::CFG_RESET;

    localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;

    // phase codes
    localparam logic [1:0] PH_LOADING   = 2'd0;
    localparam logic [1:0] PH_COMPUTING = 2'd1;
    localparam logic [1:0] PH_READING   = 2'd2;

    // relaxation sub-step
    localparam logic SUB_VIA  = 1'b0;
    localparam logic SUB_CELL = 1'b1;

    // control state
    logic [1:0]    r_phase,     n_phase;
    logic          r_sub,       n_sub;
    logic [VW-1:0] r_piv,       n_piv;
    logic [VW-1:0] r_row,       n_row;
    logic [VW-1:0] r_col,       n_col;
    logic [VW-1:0] r_last,      n_last;   // N-1
    logic          r_via_pend,  n_via_pend;
    logic          r_cell_pend, n_cell_pend;
    logic          r_out_valid, n_out_valid;

    // payload state
    logic [VW-1:0]         r_wr_row, n_wr_row;
    logic [VW-1:0]         r_wr_col, n_wr_col;
    logic [DIST_WIDTH-1:0] r_via;
    logic                  r_out_last, n_out_last;

    // RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DIST_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr_a;
    logic [DIST_WIDTH-1:0] ram_rdata_a;
    logic [DIST_WIDTH-1:0] ram_rdata_b;

    logic                  cmd_acc;
    logic                  load_acc;
    logic                  read_acc;
    logic                  row_end;
    logic                  mat_end;
    logic [CW-1:0]         cfg_ext;
    logic [CW-1:0]         cfg_side;
    logic [LW-1:0]         w_wide;
    logic [DIST_WIDTH-1:0] load_val;
    logic [DIST_WIDTH:0]   path_sum;
    logic [DIST_WIDTH-1:0] cand;
    logic [DIST_WIDTH-1:0] relax_val;
    logic [XW-1:0]         out_wide;

    assign busy     = (r_phase == PH_COMPUTING) || r_cell_pend;
    assign cmd_acc  = start && !busy;
    assign load_acc = cmd_acc && (i_cmd.opcode == apsp_pkg::OP_LOAD)
                      && (r_phase == PH_LOADING);
    assign read_acc = cmd_acc && (i_cmd.opcode == apsp_pkg::OP_READ)
                      && (r_phase == PH_READING);
    assign row_end  = (r_col == r_last);
    assign mat_end  = row_end && (r_row == r_last);

    // vertex count: zero acts as one, large values clamp
    always_comb begin
        cfg_ext = CW'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_side = CW'(1);
        end else if (cfg_ext > CW'(MAX_VERTICES)) begin
            cfg_side = CW'(MAX_VERTICES);
        end else begin
            cfg_side = cfg_ext;
        end
    end

    // load value: off-diagonal zero means no edge, oversized weight saturates
    always_comb begin
        w_wide = LW'(i_cmd.edge_weight);
        if ((i_cmd.edge_weight == '0) && (r_row != r_col)) begin
            load_val = DIST_INF;
        end else if (w_wide >= LW'(DIST_INF)) begin
            load_val = DIST_INF;
        end else begin
            load_val = w_wide[DIST_WIDTH-1:0];
        end
    end

    // saturating path sum through the pivot, then keep the smaller
    always_comb begin
        path_sum = {1'b0, r_via} + {1'b0, ram_rdata_a};
        if ((r_via == DIST_INF) || (ram_rdata_a == DIST_INF)
                || (path_sum >= {1'b0, DIST_INF})) begin
            cand = DIST_INF;
        end else begin
            cand = path_sum[DIST_WIDTH-1:0];
        end
        relax_val = (cand < ram_rdata_b) ? cand : ram_rdata_b;
    end

    // Port A: via fetch or pivot-row entry. Port B: the cell itself, or the
    // distance being read out. Pivot row and column never change under their
    // own pivot, and a write always lands on a cell already read, so there is
    // no same-entry overlap to forward.
    assign ram_raddr_a = (r_sub == SUB_VIA) ? {r_row, r_piv} : {r_piv, r_col};
    assign ram_we      = r_cell_pend || load_acc;
    assign ram_waddr   = r_cell_pend ? {r_wr_row, r_wr_col} : {r_row, r_col};
    assign ram_wdata   = r_cell_pend ? relax_val : load_val;

    apsp_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b ({r_row, r_col}),
        .o_rdata_b (ram_rdata_b)
    );

    // sequencer
    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_piv       = r_piv;
        n_row       = r_row;
        n_col       = r_col;
        n_last      = r_last;
        n_via_pend  = 1'b0;
        n_cell_pend = 1'b0;
        n_out_valid = 1'b0;
        n_out_last  = r_out_last;
        n_wr_row    = r_wr_row;
        n_wr_col    = r_wr_col;

        if (i_cfg_we) begin
            // new vertex count aborts whatever job is running
            n_last  = VW'(cfg_side - CW'(1));
            n_phase = PH_LOADING;
            n_sub   = SUB_VIA;
            n_piv   = '0;
            n_row   = '0;
            n_col   = '0;
        end else begin
            case (r_phase)
                PH_LOADING: begin
                    if (load_acc) begin
                        if (mat_end) begin
                            n_row   = '0;
                            n_col   = '0;
                            n_piv   = '0;
                            n_sub   = SUB_VIA;
                            n_phase = PH_COMPUTING;
                        end else if (row_end) begin
                            n_col = '0;
                            n_row = r_row + VW'(1);
                        end else begin
                            n_col = r_col + VW'(1);
                        end
                    end
                end
                PH_COMPUTING: begin
                    if (r_sub == SUB_VIA) begin
                        n_via_pend = 1'b1;
                        n_sub      = SUB_CELL;
                    end else begin
                        n_cell_pend = 1'b1;
                        n_wr_row    = r_row;
                        n_wr_col    = r_col;
                        if (row_end) begin
                            n_col = '0;
                            n_sub = SUB_VIA;
                            if (r_row == r_last) begin
                                n_row = '0;
                                if (r_piv == r_last) begin
                                    n_piv   = '0;
                                    n_phase = PH_READING;
                                end else begin
                                    n_piv = r_piv + VW'(1);
                                end
                            end else begin
                                n_row = r_row + VW'(1);
                            end
                        end else begin
                            n_col = r_col + VW'(1);
                        end
                    end
                end
                PH_READING: begin
                    if (read_acc) begin
                        n_out_valid = 1'b1;
                        n_out_last  = mat_end;
                        if (mat_end) begin
                            n_row   = '0;
                            n_col   = '0;
                            n_phase = PH_LOADING;
                        end else if (row_end) begin
                            n_col = '0;
                            n_row = r_row + VW'(1);
                        end else begin
                            n_col = r_col + VW'(1);
                        end
                    end
                end
                default: begin
                    n_phase = PH_LOADING;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LOADING;
            r_sub       <= SUB_VIA;
            r_piv       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_last      <= VW'(RST_SIDE - 1);
            r_via_pend  <= 1'b0;
            r_cell_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_piv       <= n_piv;
            r_row       <= n_row;
            r_col       <= n_col;
            r_last      <= n_last;
            r_via_pend  <= n_via_pend;
            r_cell_pend <= n_cell_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_wr_row   <= n_wr_row;
        r_wr_col   <= n_wr_col;
        r_out_last <= n_out_last;
        if (r_via_pend) begin
            r_via <= ram_rdata_a;
        end
    end

    // result straight from the registered RAM read
    always_comb begin
        out_wide       = XW'(ram_rdata_b);
        o_res.distance = out_wide[apsp_pkg::OUT_W-1:0];
        o_res.last     = r_out_last;
    end
    assign o_valid = r_out_valid;

    // a read result never shares a cycle with a relaxation write-back
    `APSP_ASSERT_SAME(a_no_read_during_relax, i_clk, i_rst_n, o_valid, !r_cell_pend)
    // via fetch is followed by the first cell of that row unless the vertex count is written
    `APSP_ASSERT_NEXT(a_via_then_cell, i_clk, i_rst_n, (r_phase == PH_COMPUTING) && (r_sub == SUB_VIA) && !i_cfg_we, (r_phase == PH_COMPUTING) && (r_sub == SUB_CELL))
    // final distance puts the block back into loading
    `APSP_ASSERT_SAME(a_last_restarts, i_clk, i_rst_n, o_valid && o_res.last, r_phase == PH_LOADING)
    // write-backs only come out of the relaxation sweep
    `APSP_ASSERT_SAME(a_wb_not_loading, i_clk, i_rst_n, r_cell_pend, r_phase != PH_LOADING)

endmodule

`default_nettype wire

>>> rtl/apsp_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module apsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire
